/* hdl/skst_pkg.sv */
// Shared types, widths and codes for the sorted key set table.
package skst_pkg;

    localparam int CAPACITY  = 256;
    // Stored key width; keys arrive on a 32-bit field and keep their low KEY_BITS bits.
    localparam int KEY_BITS  = 32;
    localparam int FIELD_KEY_BITS = 32;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int POS_BITS  = $clog2(CAPACITY + 1);

    localparam logic [POS_BITS-1:0] CAP_COUNT = POS_BITS'(CAPACITY);

    typedef enum logic [2:0] {
        ACT_FIND       = 3'd0,
        ACT_ADD        = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_REMOVE_AT  = 3'd3,
        ACT_GET_AT     = 3'd4,
        ACT_REPLACE_AT = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_NOT_FOUND = 3'd1,
        STATUS_DUPLICATE = 3'd2,
        STATUS_BAD_POS   = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_UP,
        S_WRITE_KEY,
        S_SHIFT_DN,
        S_GET_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        action_t                   action;
        logic [FIELD_KEY_BITS-1:0] key;
        logic [POS_BITS-1:0]       position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [POS_BITS-1:0]       found_position;
        logic [FIELD_KEY_BITS-1:0] read_key;
        logic [POS_BITS-1:0]       entry_count;
    } rsp_t;

endpackage

/* hdl/skst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/sorted_key_set_table.sv */
// Sorted key set table: ordered key storage in one RAM with a search and shift sequencer.
//
// Requests enter on req (req_valid/req_ready) as one transaction each; every request
// produces exactly one response transaction on rsp (rsp_valid/rsp_ready) carrying the
// status, the position, the key read by get_at and the entry count afterwards.
// One request is worked on at a time; req_ready is high whenever the sequencer is idle,
// even while the previous response still waits in the output register.
// Work per request is bounded by the single RAM read port (one read per cycle,
// registered read data):
//   find:       binary search, at most log2(count)+1 probes of a read and a compare,
//               plus a final read state when the search window runs empty
//   add:        as find, then when the key goes in a shift up and the key write
//   insert_at:  a shift up from the top entry to the position, then the key write
//   remove_at:  a shift down from the position to the top entry
//   get_at:     one read;   replace_at, rejected requests and unused codes: no RAM read
// A stalled receiver holds the response in the output register; the sequencer then
// waits with its finished result until the register frees up.
// Reset clears the entry count and the control state; RAM contents are left as is,
// since only entries below the count are ever used.
module sorted_key_set_table
    import skst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t              state_reg, state_next;
    logic [POS_BITS-1:0] count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                wpend_reg, wpend_next;

    action_t               action_reg, action_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [POS_BITS-1:0]   off_reg, off_next;
    logic [POS_BITS-1:0]   len_reg, len_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   idx_reg, idx_next;
    logic [POS_BITS-1:0]   j_reg, j_next;
    logic [ADDR_BITS-1:0]  wpend_addr_reg, wpend_addr_next;
    status_t               status_reg, status_next;
    logic [POS_BITS-1:0]   where_reg, where_next;
    logic [FIELD_KEY_BITS-1:0] rd_reg, rd_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [KEY_BITS-1:0]   ram_wdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [KEY_BITS-1:0]   ram_rdata;

    logic                  hit;
    logic                  miss;
    logic                  replace_now;
    logic [POS_BITS-1:0]   len_gt;
    logic [POS_BITS-1:0]   len_lt;
    logic [POS_BITS-1:0]   off_lt;
    logic                  rsp_load;

    skst_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Search window updates for a probe above and below the key
    assign len_gt = pos_reg - off_reg;
    assign len_lt = off_reg + len_reg - pos_reg - POS_BITS'(1);
    assign off_lt = pos_reg + POS_BITS'(1);

    assign replace_now = req_valid && (state_reg == S_IDLE)
                      && (req.action == ACT_REPLACE_AT) && (req.position < count_reg);

    // Write port: pending shift write, then the new key, then a direct replace
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wpend_addr_reg;
        ram_wdata = ram_rdata;
        if (wpend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WRITE_KEY)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[ADDR_BITS-1:0];
            ram_wdata = key_reg;
        end
        else if (replace_now)
        begin
            ram_we    = 1'b1;
            ram_waddr = req.position[ADDR_BITS-1:0];
            ram_wdata = req.key[KEY_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wpend_next      = 1'b0;
        wpend_addr_next = wpend_addr_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        status_next     = status_reg;
        where_next      = where_reg;
        rd_next         = rd_reg;
        ram_raddr       = '0;
        hit             = 1'b0;
        miss            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = req.position[ADDR_BITS-1:0];
                if (req_valid)
                begin
                    action_next = req.action;
                    key_next    = req.key[KEY_BITS-1:0];
                    where_next  = req.position;
                    status_next = STATUS_OK;
                    rd_next     = '0;
                    state_next  = S_DONE;
                    case (req.action)
                        ACT_FIND, ACT_ADD:
                        begin
                            off_next   = '0;
                            len_next   = count_reg;
                            pos_next   = count_reg >> 1;
                            state_next = S_SEARCH_RD;
                        end
                        ACT_INSERT_AT:
                        begin
                            if (req.position > count_reg)
                            begin
                                status_next = STATUS_BAD_POS;
                            end
                            else if (count_reg >= CAP_COUNT)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                idx_next   = req.position;
                                j_next     = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        ACT_REMOVE_AT:
                        begin
                            if (req.position >= count_reg)
                            begin
                                status_next = STATUS_BAD_POS;
                            end
                            else
                            begin
                                j_next     = req.position;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        ACT_GET_AT:
                        begin
                            if (req.position >= count_reg)
                            begin
                                status_next = STATUS_BAD_POS;
                            end
                            else
                            begin
                                state_next = S_GET_WAIT;
                            end
                        end
                        ACT_REPLACE_AT:
                        begin
                            if (req.position >= count_reg)
                            begin
                                status_next = STATUS_BAD_POS;
                            end
                        end
                        default:
                        begin
                            where_next = '0;
                        end
                    endcase
                end
            end

            S_SEARCH_RD:
            begin
                ram_raddr = pos_reg[ADDR_BITS-1:0];
                if (len_reg == '0)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    state_next = S_SEARCH_CMP;
                end
            end

            S_SEARCH_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    hit = 1'b1;
                end
                else if (ram_rdata > key_reg)
                begin
                    if (pos_reg <= off_reg)
                    begin
                        miss = 1'b1;
                    end
                    else
                    begin
                        len_next   = len_gt;
                        pos_next   = off_reg + (len_gt >> 1);
                        state_next = S_SEARCH_RD;
                    end
                end
                else
                begin
                    len_next   = len_lt;
                    off_next   = off_lt;
                    pos_next   = off_lt + (len_lt >> 1);
                    state_next = S_SEARCH_RD;
                end
            end

            S_SHIFT_UP:
            begin
                // Move entry j-1 to j, walking down to the insertion point
                ram_raddr = ADDR_BITS'(j_reg - POS_BITS'(1));
                if (j_reg > idx_reg)
                begin
                    wpend_next      = 1'b1;
                    wpend_addr_next = j_reg[ADDR_BITS-1:0];
                    j_next          = j_reg - POS_BITS'(1);
                end
                else
                begin
                    state_next = S_WRITE_KEY;
                end
            end

            S_WRITE_KEY:
            begin
                count_next = count_reg + POS_BITS'(1);
                state_next = S_DONE;
            end

            S_SHIFT_DN:
            begin
                // Move entry j+1 to j, walking up to the last entry
                ram_raddr = ADDR_BITS'(j_reg + POS_BITS'(1));
                if ((j_reg + POS_BITS'(1)) < count_reg)
                begin
                    wpend_next      = 1'b1;
                    wpend_addr_next = j_reg[ADDR_BITS-1:0];
                    j_next          = j_reg + POS_BITS'(1);
                end
                else
                begin
                    count_next = count_reg - POS_BITS'(1);
                    state_next = S_DONE;
                end
            end

            S_GET_WAIT:
            begin
                rd_next    = FIELD_KEY_BITS'(ram_rdata);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (hit)
        begin
            where_next  = pos_reg;
            status_next = (action_reg == ACT_FIND) ? STATUS_OK : STATUS_DUPLICATE;
            state_next  = S_DONE;
        end
        else if (miss)
        begin
            where_next = pos_reg;
            state_next = S_DONE;
            if (action_reg == ACT_FIND)
            begin
                status_next = STATUS_NOT_FOUND;
            end
            else if (count_reg >= CAP_COUNT)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                idx_next   = pos_reg;
                j_next     = count_reg;
                state_next = S_SHIFT_UP;
            end
        end
    end

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_valid_next          = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_next.status         = status_reg;
            rsp_next.found_position = where_reg;
            rsp_next.read_key       = rd_reg;
            rsp_next.entry_count    = count_reg;
            rsp_valid_next          = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            wpend_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            wpend_reg     <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wpend_addr_reg <= wpend_addr_next;
        action_reg     <= action_next;
        key_reg        <= key_next;
        off_reg        <= off_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        status_reg     <= status_next;
        where_reg      <= where_next;
        rd_reg         <= rd_next;
        rsp_reg        <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response raised outside the done state");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE_KEY |=> count_reg == $past(count_reg) + POS_BITS'(1))
        else $error("insert did not bump the entry count");

    a_no_write_while_idle_shift: assert property (@(posedge clk) disable iff (!rst_n)
        wpend_reg |-> $past(state_reg) == S_SHIFT_UP || $past(state_reg) == S_SHIFT_DN)
        else $error("shift write pending outside a shift");
`endif

endmodule
